// File: hw/rtl/palette_cycle_blender_core_defines.svh
// ----------------------------------------------------------------------------
// Palette cycle blender assertion macros
// Shared assertion forms for the palette cycle blender checkers.
// ----------------------------------------------------------------------------
`ifndef PALETTE_CYCLE_BLENDER_CORE_DEFINES_SVH
`define PALETTE_CYCLE_BLENDER_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is high
`define PCB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("palette cycle blender check failed");

// Next-cycle implication, checked during reset too
`define PCB_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("palette cycle blender check failed");

`endif

// File: hw/rtl/pcb_pkg.sv
// ----------------------------------------------------------------------------
// Palette cycle blender package
// Types, constants, color ROM and configuration mapping functions.
// ----------------------------------------------------------------------------
`default_nettype none

package pcb_pkg;

   localparam int unsigned ROM_DEPTH    = 12;
   localparam int unsigned POS_W        = 4;
   localparam int unsigned LEVEL_W      = 7;
   localparam int unsigned INTERVAL_W   = 10;
   localparam int unsigned WEIGHT_W     = 8;
   localparam int unsigned COLOR_W      = 24;
   localparam int unsigned TIME_W       = 32;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;

   localparam logic [POS_W-1:0]   POS_LAST    = 4'(ROM_DEPTH - 1);
   localparam logic [LEVEL_W-1:0] LEVEL_MIN   = 7'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 7'd100;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd50;
   localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 10'd1000;

   // Reciprocal products: 950/99 and 255/99 scaled by 2^23,
   // 128/255 and 127/255 scaled by 2^24
   localparam logic [26:0] INTERVAL_MUL = 27'd80497300;
   localparam logic [24:0] WEIGHT_MUL   = 25'd21607170;
   localparam logic [23:0] Q128_MUL     = 24'd8421632;
   localparam logic [23:0] Q127_MUL     = 24'd8355838;

   // Register word index (paddr[2])
   typedef enum logic {
      CSR_SPEED     = 1'b0,
      CSR_INTENSITY = 1'b1
   } csr_index_type;

   // Values derived from configuration, consumed by the datapath
   typedef struct packed {
      logic [INTERVAL_W-1:0] interval;
      logic [WEIGHT_W-1:0]   weight;
   } cfg_type;

   // Limit a level register to 1..100
   function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
      logic [LEVEL_W-1:0] r;
      r = v;
      if (v < LEVEL_MIN) begin
         r = LEVEL_MIN;
      end else if (v > LEVEL_MAX) begin
         r = LEVEL_MAX;
      end
      return r;
   endfunction

   // 1000 - floor((speed-1)*950/99)
   function automatic logic [INTERVAL_W-1:0] interval_of(input logic [LEVEL_W-1:0] v);
      logic [LEVEL_W-1:0] x;
      logic [33:0]        prod;
      x    = clamp_level(v) - LEVEL_MIN;
      prod = 34'(x) * 34'(INTERVAL_MUL);
      return INTERVAL_MAX - prod[32:23];
   endfunction

   // floor((intensity-1)*255/99)
   function automatic logic [WEIGHT_W-1:0] weight_of(input logic [LEVEL_W-1:0] v);
      logic [LEVEL_W-1:0] x;
      logic [31:0]        prod;
      x    = clamp_level(v) - LEVEL_MIN;
      prod = 32'(x) * 32'(WEIGHT_MUL);
      return prod[30:23];
   endfunction

   // Twelve-entry color ROM; unused codes read black
   function automatic logic [COLOR_W-1:0] rom_color(input logic [POS_W-1:0] idx);
      logic [COLOR_W-1:0] c;
      case (idx)
         4'd0:    c = 24'hFF0000;
         4'd1:    c = 24'hFF8000;
         4'd2:    c = 24'hFFFF00;
         4'd3:    c = 24'h80FF00;
         4'd4:    c = 24'h00FF00;
         4'd5:    c = 24'h00FF80;
         4'd6:    c = 24'h00FFFF;
         4'd7:    c = 24'h0080FF;
         4'd8:    c = 24'h0000FF;
         4'd9:    c = 24'h8000FF;
         4'd10:   c = 24'hFF00FF;
         4'd11:   c = 24'hFF0080;
         default: c = '0;
      endcase
      return c;
   endfunction

   // Step to the following ROM entry, wrapping after the last
   function automatic logic [POS_W-1:0] pos_step(input logic [POS_W-1:0] p);
      return (p >= POS_LAST) ? '0 : p + 4'd1;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pcb_if.sv
// ----------------------------------------------------------------------------
// Palette cycle blender channels
// Valid/ready interfaces for the timestamp and color channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcb_req_if
   import pcb_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, output now_ms, input ready);
   modport sink   (input valid, input now_ms, output ready);
endinterface

interface pcb_rsp_if
   import pcb_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               updated;
   logic [COLOR_W-1:0] color_rgb;

   modport source (output valid, output updated, output color_rgb, input ready);
   modport sink   (input valid, input updated, input color_rgb, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pcb_csr.sv
// ----------------------------------------------------------------------------
// Palette cycle blender registers
// APB register file for speed and intensity; keeps interval and weight
// derived at write time so the datapath sees them the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pcb_csr
   import pcb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   logic [LEVEL_W-1:0] speed_ff, speed_in;
   logic [LEVEL_W-1:0] intensity_ff, intensity_in;
   cfg_type            cfg_ff, cfg_in;
   logic               wr_en;
   csr_index_type      word_idx;

   assign pready   = 1'b1;
   assign wr_en    = psel && penable && pwrite;
   assign word_idx = csr_index_type'(paddr[2]);

   // Decode writes and refresh the derived values
   always_comb begin
      speed_in     = speed_ff;
      intensity_in = intensity_ff;
      cfg_in       = cfg_ff;
      if (wr_en) begin
         case (word_idx)
            CSR_SPEED: begin
               speed_in        = pwdata[LEVEL_W-1:0];
               cfg_in.interval = interval_of(pwdata[LEVEL_W-1:0]);
            end
            CSR_INTENSITY: begin
               intensity_in  = pwdata[LEVEL_W-1:0];
               cfg_in.weight = weight_of(pwdata[LEVEL_W-1:0]);
            end
            default: begin
               speed_in = speed_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff        <= LEVEL_RESET;
         intensity_ff    <= LEVEL_RESET;
         cfg_ff.interval <= interval_of(LEVEL_RESET);
         cfg_ff.weight   <= weight_of(LEVEL_RESET);
      end else begin
         speed_ff     <= speed_in;
         intensity_ff <= intensity_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Read back the raw register values
   always_comb begin
      case (word_idx)
         CSR_SPEED:     prdata = CSR_DATA_W'(speed_ff);
         CSR_INTENSITY: prdata = CSR_DATA_W'(intensity_ff);
         default:       prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pcb_blend.sv
// ----------------------------------------------------------------------------
// Palette cycle blender color mixer
// Looks up a ROM entry and its successor and blends toward the successor.
// ----------------------------------------------------------------------------
`default_nettype none

module pcb_blend
   import pcb_pkg::*;
(
   input  wire logic [POS_W-1:0]    pos,
   input  wire logic [WEIGHT_W-1:0] weight,
   output logic      [COLOR_W-1:0]  color
);

   logic [COLOR_W-1:0]  c_from;
   logic [COLOR_W-1:0]  c_to;
   logic [31:0]         prod128;
   logic [31:0]         prod127;
   logic [WEIGHT_W-1:0] q128;
   logic [WEIGHT_W-1:0] q127;

   // ROM channels only hold 0x00, 0x80 and 0xFF, so a channel moves by
   // 127, 128 or 255 steps: precompute floor(d*w/255) for each distance
   assign prod128 = 32'(weight) * 32'(Q128_MUL);
   assign prod127 = 32'(weight) * 32'(Q127_MUL);
   assign q128    = prod128[31:24];
   assign q127    = prod127[31:24];

   assign c_from = rom_color(pos);
   assign c_to   = rom_color(pos_step(pos));

   // Move one channel toward its target, truncating toward zero
   function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] w,
                                      input logic [7:0] s127,
                                      input logic [7:0] s128);
      logic [7:0] gap;
      logic [7:0] step;
      gap = (b > a) ? b - a : a - b;
      case (gap)
         8'd127:  step = s127;
         8'd128:  step = s128;
         8'd255:  step = w;
         default: step = '0;
      endcase
      return (b > a) ? a + step : a - step;
   endfunction

   assign color[23:16] = mix(c_from[23:16], c_to[23:16], weight, q127, q128);
   assign color[15:8]  = mix(c_from[15:8],  c_to[15:8],  weight, q127, q128);
   assign color[7:0]   = mix(c_from[7:0],   c_to[7:0],   weight, q127, q128);

endmodule

`default_nettype wire

// File: hw/rtl/pcb_pipe.sv
// ----------------------------------------------------------------------------
// Palette cycle blender pipeline
// Input register, interval check with state update, and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcb_pipe
   import pcb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [TIME_W-1:0]  in_now,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic                    out_updated,
   output logic      [COLOR_W-1:0] out_color
);

   logic               a_valid_ff, a_valid_in;
   logic [TIME_W-1:0]  a_now_ff, a_now_in;
   logic [TIME_W-1:0]  last_ff, last_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_updated_ff, out_updated_in;
   logic [COLOR_W-1:0] out_color_ff, out_color_in;

   logic               advance;
   logic               move;
   logic               hit;
   logic [TIME_W-1:0]  elapsed;
   logic [POS_W-1:0]   pos_next;
   logic [COLOR_W-1:0] blend_color;

   // The result register drains when empty or taken
   assign advance  = !out_valid_ff || out_ready;
   assign in_ready = !a_valid_ff || advance;
   assign move     = a_valid_ff && advance;

   // Compare wrapped elapsed time with the interval
   assign elapsed  = a_now_ff - last_ff;
   assign hit      = elapsed >= TIME_W'(cfg.interval);
   assign pos_next = pos_step(pos_ff);

   pcb_blend u_blend (
      .pos    (pos_next),
      .weight (cfg.weight),
      .color  (blend_color)
   );

   // Next values for input stage, state and result stage
   always_comb begin
      a_valid_in     = a_valid_ff;
      a_now_in       = a_now_ff;
      last_in        = last_ff;
      pos_in         = pos_ff;
      out_valid_in   = out_valid_ff;
      out_updated_in = out_updated_ff;
      out_color_in   = out_color_ff;
      if (in_ready) begin
         a_valid_in = in_valid;
         a_now_in   = in_now;
      end
      if (advance) begin
         out_valid_in = a_valid_ff;
      end
      if (move) begin
         out_updated_in = hit;
         out_color_in   = hit ? blend_color : '0;
         if (hit) begin
            last_in = a_now_ff;
            pos_in  = pos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         last_ff      <= '0;
         pos_ff       <= '0;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
         last_ff      <= last_in;
         pos_ff       <= pos_in;
      end
   end

   // Payload holds no reset
   always_ff @(posedge clock) begin
      a_now_ff       <= a_now_in;
      out_updated_ff <= out_updated_in;
      out_color_ff   <= out_color_in;
   end

   assign out_valid   = out_valid_ff;
   assign out_updated = out_updated_ff;
   assign out_color   = out_color_ff;

endmodule

`default_nettype wire

// File: hw/rtl/palette_cycle_blender_core.sv
// ----------------------------------------------------------------------------
// Palette cycle blender core
// Steps a twelve-color palette once per elapsed interval and reports the
// new entry blended toward the one after it.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+--------------------------------
//  req_ch  | in  | valid / ready        | now_ms[31:0]
//  rsp_ch  | out | valid / ready        | updated, color_rgb[23:0]
//  csr_*   | in  | APB psel/penable     | speed (0x0), intensity (0x4)
//
//  One timestamp per cycle unless the result side stalls; a timestamp goes
//  to the input register, then the result register: a two-entry pipeline,
//  so a word is taken while a result waits if the input register is empty.
//  The stored last-update time and palette position are updated as an item
//  enters the result register, so the following item sees them at once.
//  Synchronous active-high reset empties the pipeline and clears the state;
//  registers return to speed 50, intensity 50.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_cycle_blender_core
   import pcb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   pcb_req_if.sink                    req_ch,
   pcb_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type            cfg;
   logic               req_valid;
   logic               req_ready;
   logic [TIME_W-1:0]  req_now_ms;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_updated;
   logic [COLOR_W-1:0] rsp_color_rgb;

   // Flatten the channels
   assign req_valid        = req_ch.valid;
   assign req_now_ms       = req_ch.now_ms;
   assign req_ch.ready     = req_ready;
   assign rsp_ready        = rsp_ch.ready;
   assign rsp_ch.valid     = rsp_valid;
   assign rsp_ch.updated   = rsp_updated;
   assign rsp_ch.color_rgb = rsp_color_rgb;

   pcb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   pcb_pipe u_pipe (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_now      (req_now_ms),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_updated (rsp_updated),
      .out_color   (rsp_color_rgb)
   );

endmodule

`default_nettype wire

// File: hw/rtl/pcb_checker.sv
// ----------------------------------------------------------------------------
// Palette cycle blender checker
// Port-level properties of the core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "palette_cycle_blender_core_defines.svh"

module pcb_checker
   import pcb_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_updated,
   input wire logic [COLOR_W-1:0] rsp_color_rgb,
   input wire logic               csr_pready
);

   // No color without an update
   `PCB_ASSERT_IMPLY(a_idle_black, clock, reset, rsp_valid && !rsp_updated, rsp_color_rgb == '0)

   // A stalled word holds
   `PCB_ASSERT_NEXT(a_rsp_hold, clock, !reset && rsp_valid && !rsp_ready, reset || (rsp_valid && $stable(rsp_updated) && $stable(rsp_color_rgb)))

   // Reset empties the result stage
   `PCB_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid)

   // Register port never waits
   `PCB_ASSERT_IMPLY(a_pready, clock, reset, 1'b1, csr_pready)

endmodule

bind palette_cycle_blender_core pcb_checker u_pcb_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_updated   (rsp_updated),
   .rsp_color_rgb (rsp_color_rgb),
   .csr_pready    (csr_pready)
);

`default_nettype wire
